// ----- src/sqd_pkg.sv -----
// ----------------------------------------------------------------------------
// sqd_pkg: shared definitions for the surround to quad downmix
// Default widths, mixing coefficients, register map and fill mode codes.
// ----------------------------------------------------------------------------
package sqd_pkg;

    // Default datapath widths
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 15;

    // Fixed mixing coefficients, unsigned Q1.15
    localparam int COEF_FRAC   = 15;
    localparam int COEF_CENTER = 23170;
    localparam int COEF_LFE    = 16384;
    localparam int COEF_DUP    = 16423;

    // Number of product terms summed in one lane
    localparam int LANE_TERMS = 3;

    // Register port geometry
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int GAIN_REG_BITS = 16;

    // Register indexes (word address bits [3:2])
    localparam logic [1:0] REG_FILL_MODE = 2'd0;
    localparam logic [1:0] REG_BACK_GAIN = 2'd1;
    localparam logic [1:0] REG_SIDE_GAIN = 2'd2;

    // Rear fill mode codes; the unused fourth code behaves as difference fill
    typedef logic [1:0] fill_mode_t;
    localparam fill_mode_t FILL_OFF  = 2'd0;
    localparam fill_mode_t FILL_DUP  = 2'd1;
    localparam fill_mode_t FILL_DIFF = 2'd2;

endpackage

// ----- src/sqd_lane.sv -----
// ----------------------------------------------------------------------------
// sqd_lane: one output channel of the downmix
// Registers three signed products, then sums them, rounds half up and
// saturates to the sample range.
// ----------------------------------------------------------------------------
module sqd_lane #(
    parameter int SB    = 24,
    parameter int CW    = 17,
    parameter int SHIFT = 15
) (
    input  logic                  clk,
    input  logic                  load,
    input  logic signed [SB-1:0]  x [sqd_pkg::LANE_TERMS],
    input  logic signed [CW-1:0]  k [sqd_pkg::LANE_TERMS],
    output logic signed [SB-1:0]  y
);
    import sqd_pkg::*;

    localparam int PW = SB + CW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] HALF   = SW'(1) << (SHIFT - 1);
    localparam logic signed [SW-1:0] SAT_HI = {{(SW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_LO = {{(SW-SB+1){1'b1}}, {(SB-1){1'b0}}};

    logic signed [PW-1:0] prod_reg [LANE_TERMS];
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;

    // Product stage: one multiplier per term, registered.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < LANE_TERMS; i++)
            begin
                prod_reg[i] <= PW'(x[i]) * PW'(k[i]);
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < LANE_TERMS; i++)
        begin
            sum = sum + SW'(prod_reg[i]);
        end
        shifted = (sum + HALF) >>> SHIFT;
        if (shifted > SAT_HI)
        begin
            y = SAT_HI[SB-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            y = SAT_LO[SB-1:0];
        end
        else
        begin
            y = shifted[SB-1:0];
        end
    end

endmodule

// ----- src/sqd_regs.sv -----
// ----------------------------------------------------------------------------
// sqd_regs: configuration registers of the downmix
// APB write/read of the rear fill mode and the back and side gains.
// ----------------------------------------------------------------------------
module sqd_regs #(
    parameter int GAIN_FRAC_BITS = sqd_pkg::GAIN_FRAC_BITS_DEF,
    parameter int GRW            = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sqd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sqd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sqd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output sqd_pkg::fill_mode_t                 rear_fill_mode,
    output logic [GRW-1:0]                      back_gain,
    output logic [GRW-1:0]                      side_gain
);
    import sqd_pkg::*;

    localparam logic [GRW-1:0] GAIN_RESET = GRW'(1) << GAIN_FRAC_BITS;

    fill_mode_t     mode_reg;
    logic [GRW-1:0] back_gain_reg;
    logic [GRW-1:0] side_gain_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    // Gains take the low sixteen bits of the written word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= FILL_OFF;
            back_gain_reg <= GAIN_RESET;
            side_gain_reg <= GAIN_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FILL_MODE: mode_reg      <= pwdata[1:0];
                REG_BACK_GAIN: back_gain_reg <= GRW'(pwdata[GAIN_REG_BITS-1:0]);
                REG_SIDE_GAIN: side_gain_reg <= GRW'(pwdata[GAIN_REG_BITS-1:0]);
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FILL_MODE: prdata = APB_DATA_BITS'(mode_reg);
            REG_BACK_GAIN: prdata = APB_DATA_BITS'(back_gain_reg);
            REG_SIDE_GAIN: prdata = APB_DATA_BITS'(side_gain_reg);
            default:       prdata = '0;
        endcase
    end

    assign rear_fill_mode = mode_reg;
    assign back_gain      = back_gain_reg;
    assign side_gain      = side_gain_reg;

endmodule

// ----- src/surround_to_quad_downmix.sv -----
// ----------------------------------------------------------------------------
// surround_to_quad_downmix: 7.1 surround to four-channel downmix
// Four parallel mixing lanes, one per output channel, behind a shared
// output register.
// ----------------------------------------------------------------------------
// Usage
// The input channel carries one 7.1 frame per word (eight signed samples)
// under in_valid / in_stall; the output channel carries one four-channel word
// under out_valid / out_stall. A word is taken at a rising edge where valid
// is high and stall is low.
// Each accepted word produces exactly one output word. The lane product
// registers take it first, then the rounded and saturated result is
// registered into the output register.
// Throughput is one word per cycle while out_stall is low; the rate is set by
// the two-stage lane pipeline, every stage of which can advance in each cycle.
// When the receiver stalls, the output word holds steady and the product
// stage still takes one more word, so in_stall rises only once both stages
// are full. In_stall follows out_stall combinationally in that case.
// Reset (rst_n low, asynchronous) empties the pipeline, sets the rear fill
// mode to off and both gains to unity. Registers are written through the APB
// port; the user must write them only while the block is idle (not enforced).
// The front lanes mix centre at 0.7071 and LFE at 0.5 into each front. The
// rear lanes take the native back and side mix, or, when every back and side
// sample is zero and fill is enabled, a duplicate or difference fill.
// ----------------------------------------------------------------------------
module surround_to_quad_downmix #(
    parameter int SAMPLE_BITS    = sqd_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = sqd_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sqd_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sqd_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sqd_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    // Input words
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       in_front_left,
    input  logic signed [SAMPLE_BITS-1:0]       in_front_right,
    input  logic signed [SAMPLE_BITS-1:0]       in_center,
    input  logic signed [SAMPLE_BITS-1:0]       in_lfe,
    input  logic signed [SAMPLE_BITS-1:0]       in_back_left,
    input  logic signed [SAMPLE_BITS-1:0]       in_back_right,
    input  logic signed [SAMPLE_BITS-1:0]       in_side_left,
    input  logic signed [SAMPLE_BITS-1:0]       in_side_right,
    // Output words
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       out_front_left,
    output logic signed [SAMPLE_BITS-1:0]       out_front_right,
    output logic signed [SAMPLE_BITS-1:0]       out_rear_left,
    output logic signed [SAMPLE_BITS-1:0]       out_rear_right
);
    import sqd_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int GF  = GAIN_FRAC_BITS;
    // Gain registers hold unity even when the fraction is wider than 15 bits.
    localparam int GRW = (GF + 1 > GAIN_REG_BITS) ? GF + 1 : GAIN_REG_BITS;
    // The rear lanes work with MF fraction bits, wide enough for both the
    // gains and the fixed duplicate coefficient; extra zero bits do not
    // change the rounding.
    localparam int MF  = (GF > COEF_FRAC) ? GF : COEF_FRAC;
    localparam int CWF = COEF_FRAC + 2;
    localparam int CWR = MF + 2;
    localparam int UNITY = 1 << GF;

    localparam logic signed [CWF-1:0] K_UNIT   = CWF'(1) << COEF_FRAC;
    localparam logic signed [CWF-1:0] K_CENTER = CWF'(COEF_CENTER);
    localparam logic signed [CWF-1:0] K_LFE    = CWF'(COEF_LFE);
    localparam logic signed [CWR-1:0] K_DUP    = CWR'(COEF_DUP) << (MF - COEF_FRAC);
    localparam logic signed [CWR-1:0] K_HALF   = CWR'(1) << (MF - 1);

    fill_mode_t     rear_fill_mode;
    logic [GRW-1:0] back_gain;
    logic [GRW-1:0] side_gain;

    sqd_regs #(
        .GAIN_FRAC_BITS (GF),
        .GRW            (GRW)
    ) u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .rear_fill_mode (rear_fill_mode),
        .back_gain      (back_gain),
        .side_gain      (side_gain)
    );

    // ------------------------------------------------------------------
    // Pipeline control: product stage (stage 1) and output register.
    // ------------------------------------------------------------------
    logic prod_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic prod_ready;
    logic in_take;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign in_stall   = !prod_ready;
    assign in_take    = in_valid && prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prod_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rear path selection: native mix when any back or side sample is
    // present or fill is off; otherwise the fill chosen by the mode.
    // ------------------------------------------------------------------
    logic                  native;
    logic [GF:0]           bg_lim;
    logic [GF:0]           sg_lim;
    logic signed [CWR-1:0] bg_k;
    logic signed [CWR-1:0] sg_k;
    logic signed [CWR-1:0] rear_k0;
    logic signed [CWR-1:0] rear_k1;

    assign native = (|in_back_left) || (|in_back_right) || (|in_side_left)
                 || (|in_side_right) || (rear_fill_mode == FILL_OFF);

    // Gains above unity are limited to unity.
    assign bg_lim = (back_gain > GRW'(UNITY)) ? (GF+1)'(UNITY) : back_gain[GF:0];
    assign sg_lim = (side_gain > GRW'(UNITY)) ? (GF+1)'(UNITY) : side_gain[GF:0];
    assign bg_k   = $signed(CWR'(bg_lim) << (MF - GF));
    assign sg_k   = $signed(CWR'(sg_lim) << (MF - GF));

    always_comb
    begin
        if (native)
        begin
            rear_k0 = bg_k;
            rear_k1 = sg_k;
        end
        else if (rear_fill_mode == FILL_DUP)
        begin
            rear_k0 = K_DUP;
            rear_k1 = '0;
        end
        else
        begin
            // Difference fill: half of this side minus half of the other.
            rear_k0 = K_HALF;
            rear_k1 = -K_HALF;
        end
    end

    // ------------------------------------------------------------------
    // Lane operands
    // ------------------------------------------------------------------
    logic signed [SB-1:0]  fl_x [LANE_TERMS];
    logic signed [SB-1:0]  fr_x [LANE_TERMS];
    logic signed [SB-1:0]  rl_x [LANE_TERMS];
    logic signed [SB-1:0]  rr_x [LANE_TERMS];
    logic signed [CWF-1:0] front_k [LANE_TERMS];
    logic signed [CWR-1:0] rear_k  [LANE_TERMS];
    logic signed [SB-1:0]  fl_y;
    logic signed [SB-1:0]  fr_y;
    logic signed [SB-1:0]  rl_y;
    logic signed [SB-1:0]  rr_y;

    assign front_k[0] = K_UNIT;
    assign front_k[1] = K_CENTER;
    assign front_k[2] = K_LFE;

    assign fl_x[0] = in_front_left;
    assign fl_x[1] = in_center;
    assign fl_x[2] = in_lfe;
    assign fr_x[0] = in_front_right;
    assign fr_x[1] = in_center;
    assign fr_x[2] = in_lfe;

    assign rear_k[0] = rear_k0;
    assign rear_k[1] = rear_k1;
    assign rear_k[2] = '0;

    assign rl_x[0] = native ? in_back_left  : in_front_left;
    assign rl_x[1] = native ? in_side_left  : in_front_right;
    assign rl_x[2] = '0;
    assign rr_x[0] = native ? in_back_right : in_front_right;
    assign rr_x[1] = native ? in_side_right : in_front_left;
    assign rr_x[2] = '0;

    sqd_lane #(.SB(SB), .CW(CWF), .SHIFT(COEF_FRAC)) u_lane_fl (
        .clk (clk), .load (in_take), .x (fl_x), .k (front_k), .y (fl_y)
    );

    sqd_lane #(.SB(SB), .CW(CWF), .SHIFT(COEF_FRAC)) u_lane_fr (
        .clk (clk), .load (in_take), .x (fr_x), .k (front_k), .y (fr_y)
    );

    sqd_lane #(.SB(SB), .CW(CWR), .SHIFT(MF)) u_lane_rl (
        .clk (clk), .load (in_take), .x (rl_x), .k (rear_k), .y (rl_y)
    );

    sqd_lane #(.SB(SB), .CW(CWR), .SHIFT(MF)) u_lane_rr (
        .clk (clk), .load (in_take), .x (rr_x), .k (rear_k), .y (rr_y)
    );

    // ------------------------------------------------------------------
    // Output register: gathers the four lanes into one word.
    // ------------------------------------------------------------------
    logic signed [SB-1:0] out_front_left_reg;
    logic signed [SB-1:0] out_front_right_reg;
    logic signed [SB-1:0] out_rear_left_reg;
    logic signed [SB-1:0] out_rear_right_reg;

    always_ff @(posedge clk)
    begin
        if (out_ready && prod_valid_reg)
        begin
            out_front_left_reg  <= fl_y;
            out_front_right_reg <= fr_y;
            out_rear_left_reg   <= rl_y;
            out_rear_right_reg  <= rr_y;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_front_left  = out_front_left_reg;
    assign out_front_right = out_front_right_reg;
    assign out_rear_left   = out_rear_left_reg;
    assign out_rear_right  = out_rear_right_reg;

`ifndef SYNTH
    // An accepted word always lands in the product stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> prod_valid_reg)
        else $error("accepted word missing from product stage");

    // A blocked product stage keeps its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && !out_ready |=> prod_valid_reg)
        else $error("product stage word lost while blocked");

    // A product word moving on always becomes an output word.
    assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg && out_ready |=> out_valid_reg)
        else $error("product word not passed to output register");

    // Input is only held off when both stages are full and the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> prod_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ----- bench/surround_to_quad_downmix_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surround_to_quad_downmix_tb: self-checking bench for the 7.1 to quad downmix
// Feeds surround words through the input channel and predicts each quad
// word from a local bit-accurate mixer. Every output word is checked against
// the oldest prediction. Rear fill modes and gains are stepped over the APB
// port between phases, and both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module surround_to_quad_downmix_tb;

    import sqd_pkg::*;

    localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
    localparam int GAIN_FRAC   = GAIN_FRAC_BITS_DEF;
    localparam int CLK_HALF    = 4;

    // The unused fourth fill code and the unmapped register slot.
    localparam fill_mode_t FILL_SPARE = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [15:0] GAIN_UNITY = 16'(1 << GAIN_FRAC);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One 7.1 surround word and one quad word.
    typedef struct packed {
        sample_t fl, fr, c, lfe, bl, br, sl, sr;
    } frame_t;

    typedef struct packed {
        sample_t fl, fr, rl, rr;
    } quad_t;

    // ------------------------------------------------------------------
    // Signals to and from the block. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr  = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic        pready;

    logic        in_valid = 1'b0;
    logic        in_stall;
    sample_t     in_front_left  = '0;
    sample_t     in_front_right = '0;
    sample_t     in_center      = '0;
    sample_t     in_lfe         = '0;
    sample_t     in_back_left   = '0;
    sample_t     in_back_right  = '0;
    sample_t     in_side_left   = '0;
    sample_t     in_side_right  = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    sample_t     out_front_left;
    sample_t     out_front_right;
    sample_t     out_rear_left;
    sample_t     out_rear_right;

    // ------------------------------------------------------------------
    // Bench state: the words still to send, the quad words still awaited,
    // and our own copy of the register file.
    // ------------------------------------------------------------------
    frame_t      frames_to_send[$];
    quad_t       awaited_quads[$];
    frame_t      offered;
    quad_t       seen_quad;
    quad_t       want_quad;

    fill_mode_t  cfg_fill_mode = FILL_OFF;
    logic [15:0] cfg_back_gain = GAIN_UNITY;
    logic [15:0] cfg_side_gain = GAIN_UNITY;

    int          mismatch_count = 0;

    // Idling controls; the stimulus sets the rates on the falling edge.
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          sender_hold   = 1'b0;
    bit          hold_request  = 1'b0;
    logic        long_hold     = 1'b0;
    int          gap_left      = 0;
    int          stall_left    = 0;

    surround_to_quad_downmix DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_front_left   (in_front_left),
        .in_front_right  (in_front_right),
        .in_center       (in_center),
        .in_lfe          (in_lfe),
        .in_back_left    (in_back_left),
        .in_back_right   (in_back_right),
        .in_side_left    (in_side_left),
        .in_side_right   (in_side_right),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_front_left  (out_front_left),
        .out_front_right (out_front_right),
        .out_rear_left   (out_rear_left),
        .out_rear_right  (out_rear_right)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Mixer prediction. All arithmetic is carried in 64 bits, which holds
    // every product and sum exactly at these widths.
    // ------------------------------------------------------------------
    function automatic longint widen(sample_t s);
        return s;
    endfunction

    // Round half up onto the coarser grid: add half an LSB, then shift
    // arithmetically, which floors for negative sums as well.
    function automatic longint round_half_up(longint v, int shift);
        return (v + (longint'(1) << (shift - 1))) >>> shift;
    endfunction

    function automatic sample_t clip_sample(longint v);
        if (v > widen(PEAK_POS))
            return PEAK_POS;
        if (v < widen(PEAK_NEG))
            return PEAK_NEG;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic longint limited_gain(logic [15:0] g);
        longint lg;
        lg = g;
        return (g > GAIN_UNITY) ? longint'(GAIN_UNITY) : lg;
    endfunction

    function automatic quad_t downmix_frame(frame_t f);
        longint common;
        longint unit;
        longint bg;
        longint sg;
        bit     native;
        quad_t  q;
        unit   = longint'(1) << COEF_FRAC;
        common = COEF_CENTER * widen(f.c) + COEF_LFE * widen(f.lfe);
        q.fl   = clip_sample(round_half_up(widen(f.fl) * unit + common, COEF_FRAC));
        q.fr   = clip_sample(round_half_up(widen(f.fr) * unit + common, COEF_FRAC));
        // Any single non-zero back or side sample keeps the native rear mix.
        native = (f.bl != 0) || (f.br != 0) || (f.sl != 0) || (f.sr != 0);
        if (native || cfg_fill_mode == FILL_OFF)
        begin
            bg   = limited_gain(cfg_back_gain);
            sg   = limited_gain(cfg_side_gain);
            q.rl = clip_sample(round_half_up(bg * widen(f.bl) + sg * widen(f.sl), GAIN_FRAC));
            q.rr = clip_sample(round_half_up(bg * widen(f.br) + sg * widen(f.sr), GAIN_FRAC));
        end
        else if (cfg_fill_mode == FILL_DUP)
        begin
            q.rl = clip_sample(round_half_up(COEF_DUP * widen(f.fl), COEF_FRAC));
            q.rr = clip_sample(round_half_up(COEF_DUP * widen(f.fr), COEF_FRAC));
        end
        else
        begin
            // Difference fill; the spare code lands here too.
            q.rl = clip_sample(round_half_up(widen(f.fl) - widen(f.fr), 1));
            q.rr = clip_sample(round_half_up(widen(f.fr) - widen(f.fl), 1));
        end
        return q;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generators.
    // ------------------------------------------------------------------
    function automatic frame_t make_frame(sample_t fl, sample_t fr, sample_t c,
                                          sample_t lfe, sample_t bl, sample_t br,
                                          sample_t sl, sample_t sr);
        return '{fl, fr, c, lfe, bl, br, sl, sr};
    endfunction

    // Biased towards the rails, zero and tiny values, where rounding and
    // saturation live; otherwise uniform over the whole code range.
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return PEAK_POS;
            1:       return PEAK_NEG;
            2:       return '0;
            3:       return sample_t'(int'($urandom_range(8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(3))
            0:       return '0;
            1:       return GAIN_UNITY;
            2:       return 16'($urandom_range(16'hFFFF, GAIN_UNITY + 1));
            default: return 16'($urandom_range(GAIN_UNITY, 0));
        endcase
    endfunction

    // Half of the random words have a silent rear so that the fill paths
    // are exercised as often as the native mix.
    function automatic frame_t random_frame();
        frame_t f;
        f = make_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                       '0, '0, '0, '0);
        if ($urandom_range(1))
        begin
            f.bl = pick_sample();
            f.br = pick_sample();
            f.sl = pick_sample();
            f.sr = pick_sample();
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge where psel, penable, pwrite and pready are all high.
    // Only called while the block is idle.
    // ------------------------------------------------------------------
    task automatic apb_write(logic [1:0] index, logic [APB_DATA_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Writes to the unmapped slot leave the registers alone.
        case (index)
            REG_FILL_MODE: cfg_fill_mode = value[1:0];
            REG_BACK_GAIN: cfg_back_gain = value[15:0];
            REG_SIDE_GAIN: cfg_side_gain = value[15:0];
            default: ;
        endcase
    endtask

    // Wait until every word is sent and every quad word has come back, then
    // give the two-stage pipeline time to settle.
    task automatic drain();
        while (frames_to_send.size() != 0 || in_valid || awaited_quads.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver. A word is predicted at the edge where it is taken, so
    // the prediction always uses the register copy that the block sees.
    // Valid drops only after a word has gone, never because of a stall.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_quads.push_back(downmix_frame(offered));
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (frames_to_send.size() != 0 && !sender_hold)
                begin
                    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
                    begin
                        // This cycle opens an idle gap in the input.
                        gap_left = $urandom_range(13, 0);
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        offered = frames_to_send.pop_front();
                        in_front_left  <= offered.fl;
                        in_front_right <= offered.fr;
                        in_center      <= offered.c;
                        in_lfe         <= offered.lfe;
                        in_back_left   <= offered.bl;
                        in_back_right  <= offered.br;
                        in_side_left   <= offered.sl;
                        in_side_right  <= offered.sr;
                        in_valid       <= 1'b1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver. The long hold-off overrides the random stall bursts.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (long_hold)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(13, 0);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // A single long hold-off of the receiver, counted here in cycles, so
    // that both pipeline stages fill and the block stalls its input.
    initial
    begin
        wait (hold_request);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (80) @(posedge clk);
        long_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Output monitor: each quad word taken is matched with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_quad = '{out_front_left, out_front_right, out_rear_left, out_rear_right};
            if (awaited_quads.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected quad word fl=%0d fr=%0d rl=%0d rr=%0d",
                             $realtime, seen_quad.fl, seen_quad.fr,
                             seen_quad.rl, seen_quad.rr);
            end
            else
            begin
                want_quad = awaited_quads.pop_front();
                if (want_quad.fl !== seen_quad.fl || want_quad.fr !== seen_quad.fr ||
                    want_quad.rl !== seen_quad.rl || want_quad.rr !== seen_quad.rr)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: quad word mismatch expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $realtime, want_quad.fl, want_quad.fr, want_quad.rl,
                                 want_quad.rr, seen_quad.fl, seen_quad.fr,
                                 seen_quad.rl, seen_quad.rr);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence: a directed part that walks the rails, each fill
    // mode and the special cases, then random phases with fresh settings.
    // ------------------------------------------------------------------
    initial
    begin
        fill_mode_t mode_cycle[4];
        logic [15:0] bg;
        logic [15:0] sg;
        mode_cycle = '{FILL_OFF, FILL_DUP, FILL_DIFF, FILL_SPARE};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n         = 1'b1;
        send_idle_pct = 30;
        stall_pct     = 30;

        // Reset settings: fill off, both gains at unity.
        frames_to_send.push_back(make_frame('0, '0, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS,
                                            PEAK_POS, PEAK_POS, PEAK_POS, PEAK_POS));
        frames_to_send.push_back(make_frame(PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG,
                                            PEAK_NEG, PEAK_NEG, PEAK_NEG, PEAK_NEG));
        frames_to_send.push_back(make_frame(PEAK_NEG, PEAK_POS, PEAK_NEG, PEAK_POS,
                                            PEAK_POS, PEAK_NEG, PEAK_NEG, PEAK_POS));
        frames_to_send.push_back(make_frame('0, '0, PEAK_POS, PEAK_NEG, '0, '0, '0, '0));
        // A single LSB on one back sample already counts as rear present.
        frames_to_send.push_back(make_frame(-24'sd5, 24'sd7, '0, '0, 24'sd1, '0, '0, '0));
        frames_to_send.push_back(make_frame(pick_sample(), pick_sample(), 24'sd1,
                                            -24'sd1, '0, '0, '0, '0));
        drain();

        // Duplicate fill, with both gains above unity so they are limited.
        apb_write(REG_FILL_MODE, FILL_DUP);
        apb_write(REG_BACK_GAIN, 32'h0000_FFFF);
        apb_write(REG_SIDE_GAIN, GAIN_UNITY + 1);
        frames_to_send.push_back(make_frame(PEAK_POS, PEAK_NEG, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(-24'sd1, 24'sd1, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(PEAK_POS, 24'sd3, '0, '0, '0, '0, -24'sd1, '0));
        frames_to_send.push_back(make_frame('0, '0, '0, '0, PEAK_POS, PEAK_NEG,
                                            PEAK_POS, PEAK_NEG));
        drain();

        // Difference fill with both gains at zero.
        apb_write(REG_FILL_MODE, FILL_DIFF);
        apb_write(REG_BACK_GAIN, 32'd0);
        apb_write(REG_SIDE_GAIN, 32'd0);
        frames_to_send.push_back(make_frame(PEAK_POS, PEAK_NEG, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(PEAK_NEG, PEAK_POS, '0, '0, '0, '0, '0, '0));
        // Half an LSB each way: rounds up on one side, to zero on the other.
        frames_to_send.push_back(make_frame(24'sd1, '0, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(24'sd9, 24'sd2, '0, '0, '0, PEAK_POS, '0, '0));
        drain();

        // Spare fill code, then a write to the unmapped slot that must be
        // ignored.
        apb_write(REG_FILL_MODE, FILL_SPARE);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        frames_to_send.push_back(make_frame(24'sd3, -24'sd4, '0, '0, '0, '0, '0, '0));
        frames_to_send.push_back(make_frame(pick_sample(), pick_sample(), pick_sample(),
                                            pick_sample(), '0, '0, '0, '0));
        drain();

        // Random phases: each one steps the fill mode and draws new gains;
        // the first two pin the gains to unity and to zero.
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                bg = GAIN_UNITY;
                sg = GAIN_UNITY;
            end
            else if (phase == 1)
            begin
                bg = '0;
                sg = '0;
            end
            else
            begin
                bg = pick_gain();
                sg = pick_gain();
            end
            apb_write(REG_FILL_MODE, mode_cycle[phase % 4]);
            apb_write(REG_BACK_GAIN, bg);
            apb_write(REG_SIDE_GAIN, sg);

            @(negedge clk);
            if (phase == 3 || phase == 7)
            begin
                // A stretch with no idling at all; the run ends on one.
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else if (phase == 2)
            begin
                // Sender keeps offering while the receiver holds off.
                send_idle_pct = 0;
                stall_pct     = 0;
                hold_request  = 1'b1;
            end
            else
            begin
                send_idle_pct = $urandom_range(40, 10);
                stall_pct     = $urandom_range(40, 10);
            end

            repeat (30) frames_to_send.push_back(random_frame());
            if (phase == 5)
            begin
                // The sender pauses until every awaited quad word is in.
                while (frames_to_send.size() != 0)
                    @(negedge clk);
                sender_hold = 1'b1;
                repeat (30) frames_to_send.push_back(random_frame());
                while (in_valid || awaited_quads.size() != 0)
                    @(negedge clk);
                sender_hold = 1'b0;
            end
            else
            begin
                repeat (30) frames_to_send.push_back(random_frame());
            end
            drain();
        end

        repeat (6) @(posedge clk);
        if (mismatch_count == 0 && awaited_quads.size() == 0)
            $display("surround_to_quad_downmix verification clean");
        else
            $display("surround_to_quad_downmix verification failed");
        $finish;
    end

    // Safety net: the slowest correct run ends far earlier than this.
    initial
    begin
        #2_000_000;
        $display("surround_to_quad_downmix verification failed");
        $finish;
    end

endmodule
